### hw/rtl/tlt_pkg.sv
// ----------------------------------------------------------------------------
// tlt_pkg
// Shared widths, codes and the slot entry type of the thread leak tracker.
// ----------------------------------------------------------------------------
package tlt_pkg;

  localparam int unsigned DEPTH  = 32;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  localparam int unsigned OP_W   = 3;
  localparam int unsigned STS_W  = 3;
  localparam int unsigned KEY_W  = 64;
  localparam int unsigned TID_W  = 22;
  localparam int unsigned TIME_W = 63;
  localparam int unsigned MS_W   = 27;
  localparam int unsigned MUL_W  = 20;
  localparam int unsigned DLY_W  = MS_W + MUL_W;

  localparam logic [DLY_W-1:0] NS_PER_MS = DLY_W'(1000000);

  // opcodes
  localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
  localparam logic [OP_W-1:0] OP_JOIN   = 3'd1;
  localparam logic [OP_W-1:0] OP_DETACH = 3'd2;
  localparam logic [OP_W-1:0] OP_EXIT   = 3'd3;
  localparam logic [OP_W-1:0] OP_REPORT = 3'd4;

  // result status
  localparam logic [STS_W-1:0] STS_OK      = 3'd0;
  localparam logic [STS_W-1:0] STS_IGNORED = 3'd1;
  localparam logic [STS_W-1:0] STS_FULL    = 3'd2;
  localparam logic [STS_W-1:0] STS_LEAK    = 3'd3;
  localparam logic [STS_W-1:0] STS_NO_DUE  = 3'd4;

  typedef struct packed {
    logic              leaked;
    logic              released;
    logic [KEY_W-1:0]  handle;
    logic [TID_W-1:0]  tid;
    logic [TIME_W-1:0] created;
    logic [TIME_W-1:0] started;
    logic [TIME_W-1:0] exited;
  } entry_t;

endpackage

### hw/rtl/tlt_in_if.sv
// ----------------------------------------------------------------------------
// tlt_in_if
// Event channel: one beat carries one tracker operation.
// ----------------------------------------------------------------------------
interface tlt_in_if;
  logic                        valid;
  logic                        ready;
  logic [tlt_pkg::OP_W-1:0]    opcode;
  logic [tlt_pkg::KEY_W-1:0]   thread_key;
  logic [tlt_pkg::TID_W-1:0]   kernel_tid;
  logic                        detached_at_create;
  logic [tlt_pkg::TIME_W-1:0]  event_time;
  logic [tlt_pkg::TIME_W-1:0]  spawn_time;

  modport source (
    output valid, opcode, thread_key, kernel_tid, detached_at_create, event_time,
           spawn_time,
    input  ready
  );
  modport sink (
    input  valid, opcode, thread_key, kernel_tid, detached_at_create, event_time,
           spawn_time,
    output ready
  );
endinterface

### hw/rtl/tlt_out_if.sv
// ----------------------------------------------------------------------------
// tlt_out_if
// Result channel: one beat carries one status or leak record.
// ----------------------------------------------------------------------------
interface tlt_out_if;
  logic                        valid;
  logic                        ready;
  logic [tlt_pkg::STS_W-1:0]   status;
  logic [tlt_pkg::KEY_W-1:0]   leak_key;
  logic [tlt_pkg::TID_W-1:0]   leak_tid;
  logic [tlt_pkg::TIME_W-1:0]  leak_spawn_time;
  logic [tlt_pkg::TIME_W-1:0]  leak_start_time;
  logic [tlt_pkg::TIME_W-1:0]  leak_exit_time;
  logic                        last;

  modport source (
    output valid, status, leak_key, leak_tid, leak_spawn_time, leak_start_time,
           leak_exit_time, last,
    input  ready
  );
  modport sink (
    input  valid, status, leak_key, leak_tid, leak_spawn_time, leak_start_time,
           leak_exit_time, last,
    output ready
  );
endinterface

### hw/rtl/tlt_cfg_if.sv
// ----------------------------------------------------------------------------
// tlt_cfg_if
// Configuration write channel for the leak grace period.
// ----------------------------------------------------------------------------
interface tlt_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [tlt_pkg::MS_W-1:0]  leak_delay_ms;

  modport source (output valid, leak_delay_ms, input ready);
  modport sink   (input valid, leak_delay_ms, output ready);
endinterface

### hw/rtl/tlt_cfg.sv
// ----------------------------------------------------------------------------
// tlt_cfg
// Grace period register; converts milliseconds to nanoseconds once per write.
// ----------------------------------------------------------------------------
module tlt_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  tlt_cfg_if.sink                    cfg_i,
  output logic [tlt_pkg::DLY_W-1:0]  delay_ns_o
);

  logic [tlt_pkg::DLY_W-1:0] delay_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= '0;
    end else if (cfg_i.valid) begin
      // 27 x 20 product, in place from the cycle after the write
      delay_q <= {{tlt_pkg::MUL_W{1'b0}}, cfg_i.leak_delay_ms} * tlt_pkg::NS_PER_MS;
    end
  end

  assign delay_ns_o = delay_q;

endmodule

### hw/rtl/thread_leak_tracker_top.sv
// ----------------------------------------------------------------------------
// thread_leak_tracker_top
// Slot table of tracked threads kept in one synchronous memory, swept once
// per operation.
//
//   channel  dir  modport  beat
//   in_i     in   sink     one operation (add, join, detach, exit, report)
//   out_o    out  source   one status or leak record, last on final beat
//   cfg_i    in   sink     grace period in ms
//
// Every operation sweeps all DEPTH slots, one memory read per cycle
// unless the sweep is stalled, through the single read port of the slot
// memory; a new operation is accepted only while the tracker is idle.
// A report stalls its sweep while a leak record waits behind a full output.
// Every operation holds its final result until the output register frees.
// Reset clears the slot valid flops at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module thread_leak_tracker_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  tlt_in_if.sink     in_i,
  tlt_out_if.source  out_o,
  tlt_cfg_if.sink    cfg_i
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam int unsigned DEPTH  = tlt_pkg::DEPTH;
  localparam int unsigned IDX_W  = tlt_pkg::IDX_W;
  localparam int unsigned CNT_W  = tlt_pkg::CNT_W;
  localparam int unsigned TIME_W = tlt_pkg::TIME_W;
  localparam int unsigned DLY_W  = tlt_pkg::DLY_W;

  logic [DLY_W-1:0] delay_ns;

  tlt_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_i),
    .delay_ns_o (delay_ns)
  );

  // control state
  logic [1:0]               state_q;
  logic [DEPTH-1:0]         valid_q;
  logic [CNT_W-1:0]         rd_addr_q;
  logic                     chk_vld_q;
  logic [IDX_W-1:0]         chk_idx_q;
  logic                     live_fnd_q, leak_fnd_q, free_fnd_q, pend_vld_q;
  logic                     out_vld_q;

  // captured operation
  logic [tlt_pkg::OP_W-1:0]   op_q;
  logic [tlt_pkg::KEY_W-1:0]  key_q;
  logic [tlt_pkg::TID_W-1:0]  tid_q;
  logic                       det_q;
  logic [TIME_W-1:0]          time_q, ctime_q, thr_q;
  logic                       thr_ok_q;

  // sweep results
  logic [IDX_W-1:0]         live_idx_q, leak_idx_q, free_idx_q;
  tlt_pkg::entry_t          live_ent_q, pend_q, rd_data_q;

  // output register
  logic [tlt_pkg::STS_W-1:0] out_status_q;
  tlt_pkg::entry_t           out_ent_q;
  logic                      out_last_q;

  tlt_pkg::entry_t slot_mem_q [DEPTH];

  logic             accept, out_free, chk_live, key_eq;
  logic             live_hit, leak_hit, free_hit, due_hit;
  logic             stall, adv, rd_en, scan_end, done_fire;
  logic [TIME_W:0]  thr_diff;

  logic                      mem_we;
  logic [IDX_W-1:0]          mem_waddr;
  tlt_pkg::entry_t           mem_wdata;
  logic                      vset, vclr;
  logic [IDX_W-1:0]          vset_idx, vclr_idx;
  logic                      out_load, out_last_d;
  logic [tlt_pkg::STS_W-1:0] out_status_d;
  tlt_pkg::entry_t           out_ent_d;
  tlt_pkg::entry_t           new_ent;

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign out_free   = !out_vld_q || out_o.ready;

  // now - delay; negative means nothing can be due
  assign thr_diff = {1'b0, in_i.event_time} - {{(TIME_W + 1 - DLY_W){1'b0}}, delay_ns};

  assign chk_live = chk_vld_q && valid_q[chk_idx_q];
  assign key_eq   = (rd_data_q.handle == key_q);
  assign live_hit = chk_live && !rd_data_q.leaked && key_eq;
  assign leak_hit = chk_live && rd_data_q.leaked && key_eq;
  assign free_hit = chk_vld_q && !valid_q[chk_idx_q];
  assign due_hit  = (op_q == tlt_pkg::OP_REPORT) && chk_live && rd_data_q.leaked &&
                    thr_ok_q && (rd_data_q.exited < thr_q);

  // a second due record needs the pending one moved out first
  assign stall     = due_hit && pend_vld_q && !out_free;
  assign adv       = (state_q == ST_SCAN) && !stall;
  assign rd_en     = adv && (rd_addr_q != CNT_W'(DEPTH));
  assign scan_end  = (state_q == ST_SCAN) && !chk_vld_q && (rd_addr_q == CNT_W'(DEPTH));
  assign done_fire = (state_q == ST_DONE) && out_free;

  always_comb begin
    new_ent          = '0;
    new_ent.released = det_q;
    new_ent.handle   = key_q;
    new_ent.tid      = tid_q;
    new_ent.created  = ctime_q;
    new_ent.started  = time_q;
  end

  always_comb begin
    mem_we       = 1'b0;
    mem_waddr    = live_idx_q;
    mem_wdata    = live_ent_q;
    vset         = 1'b0;
    vset_idx     = free_idx_q;
    vclr         = 1'b0;
    vclr_idx     = leak_idx_q;
    out_load     = 1'b0;
    out_status_d = tlt_pkg::STS_OK;
    out_ent_d    = '0;
    out_last_d   = 1'b1;

    if (adv && due_hit) begin
      vclr     = 1'b1;
      vclr_idx = chk_idx_q;
      if (pend_vld_q) begin
        out_load     = 1'b1;
        out_status_d = tlt_pkg::STS_LEAK;
        out_ent_d    = pend_q;
        out_last_d   = 1'b0;
      end
    end

    if (done_fire) begin
      out_load = 1'b1;
      unique case (op_q)
        tlt_pkg::OP_ADD: begin
          if (live_fnd_q) begin
            out_status_d = tlt_pkg::STS_IGNORED;
          end else if (!free_fnd_q) begin
            out_status_d = tlt_pkg::STS_FULL;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = free_idx_q;
            mem_wdata = new_ent;
            vset      = 1'b1;
          end
        end
        tlt_pkg::OP_JOIN, tlt_pkg::OP_DETACH: begin
          if (live_fnd_q) begin
            mem_we             = 1'b1;
            mem_wdata.released = 1'b1;
          end else if (leak_fnd_q) begin
            vclr = 1'b1;
          end else begin
            out_status_d = tlt_pkg::STS_IGNORED;
          end
        end
        tlt_pkg::OP_EXIT: begin
          if (!live_fnd_q) begin
            out_status_d = tlt_pkg::STS_IGNORED;
          end else if (live_ent_q.released) begin
            vclr     = 1'b1;
            vclr_idx = live_idx_q;
          end else begin
            // replace an older leaked entry with the same key
            vclr             = leak_fnd_q;
            mem_we           = 1'b1;
            mem_wdata.leaked = 1'b1;
            mem_wdata.exited = time_q;
          end
        end
        tlt_pkg::OP_REPORT: begin
          if (pend_vld_q) begin
            out_status_d = tlt_pkg::STS_LEAK;
            out_ent_d    = pend_q;
          end else begin
            out_status_d = tlt_pkg::STS_NO_DUE;
          end
        end
        default: begin
          out_status_d = tlt_pkg::STS_IGNORED;
        end
      endcase
    end
  end

  // slot memory, one read and one write port, registered read data
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem_q[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_q <= slot_mem_q[rd_addr_q[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      valid_q    <= '0;
      rd_addr_q  <= '0;
      chk_vld_q  <= 1'b0;
      live_fnd_q <= 1'b0;
      leak_fnd_q <= 1'b0;
      free_fnd_q <= 1'b0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (vset) begin
        valid_q[vset_idx] <= 1'b1;
      end
      if (vclr) begin
        valid_q[vclr_idx] <= 1'b0;
      end

      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q    <= ST_SCAN;
            rd_addr_q  <= '0;
            chk_vld_q  <= 1'b0;
            live_fnd_q <= 1'b0;
            leak_fnd_q <= 1'b0;
            free_fnd_q <= 1'b0;
            pend_vld_q <= 1'b0;
          end
        end
        ST_SCAN: begin
          if (adv) begin
            chk_vld_q <= rd_en;
            if (rd_en) begin
              rd_addr_q <= rd_addr_q + CNT_W'(1);
            end
            if (live_hit && !live_fnd_q) begin
              live_fnd_q <= 1'b1;
            end
            if (leak_hit && !leak_fnd_q) begin
              leak_fnd_q <= 1'b1;
            end
            if (free_hit && !free_fnd_q) begin
              free_fnd_q <= 1'b1;
            end
            if (due_hit) begin
              pend_vld_q <= 1'b1;
            end
          end
          if (scan_end) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= in_i.opcode;
      key_q    <= in_i.thread_key;
      tid_q    <= in_i.kernel_tid;
      det_q    <= in_i.detached_at_create;
      time_q   <= in_i.event_time;
      ctime_q  <= in_i.spawn_time;
      thr_q    <= thr_diff[TIME_W-1:0];
      thr_ok_q <= !thr_diff[TIME_W];
    end
    if (adv) begin
      if (rd_en) begin
        chk_idx_q <= rd_addr_q[IDX_W-1:0];
      end
      if (live_hit && !live_fnd_q) begin
        live_idx_q <= chk_idx_q;
        live_ent_q <= rd_data_q;
      end
      if (leak_hit && !leak_fnd_q) begin
        leak_idx_q <= chk_idx_q;
      end
      if (free_hit && !free_fnd_q) begin
        free_idx_q <= chk_idx_q;
      end
      if (due_hit) begin
        pend_q <= rd_data_q;
      end
    end
    if (out_load) begin
      out_status_q <= out_status_d;
      out_ent_q    <= out_ent_d;
      out_last_q   <= out_last_d;
    end
  end

  assign out_o.valid            = out_vld_q;
  assign out_o.status           = out_status_q;
  assign out_o.leak_key         = out_ent_q.handle;
  assign out_o.leak_tid         = out_ent_q.tid;
  assign out_o.leak_spawn_time  = out_ent_q.created;
  assign out_o.leak_start_time  = out_ent_q.started;
  assign out_o.leak_exit_time   = out_ent_q.exited;
  assign out_o.last             = out_last_q;

  // only a report sweep can hold a pending record or stall
  a_pend_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_vld_q |-> (op_q == tlt_pkg::OP_REPORT))
    else $error("pending leak record outside a report");

  a_stall_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |-> ((state_q == ST_SCAN) && out_vld_q && pend_vld_q))
    else $error("sweep stalled without a waiting record");

  a_write_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_DONE))
    else $error("slot memory written during a sweep");

  a_done_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_fire |=> (out_vld_q && (state_q == ST_IDLE) && out_last_q))
    else $error("final result missing after sweep");

  a_scan_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_end |=> (state_q == ST_DONE))
    else $error("sweep did not finish");

endmodule

### verif/thread_leak_tracker_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thread_leak_tracker_top_tb
// Self-checking bench for the thread leak tracker. A shadow slot table
// predicts each status and leak record where no expected status is given.
// The bench runs a directed table, then a full-table sweep under output
// back-pressure, then random add, join, detach, exit and report traffic
// under several grace periods. Both channels idle at random.
// ----------------------------------------------------------------------------
module thread_leak_tracker_top_tb;
  import tlt_pkg::*;

  localparam logic [OP_W-1:0]   OP_RSVD_A    = 3'd5;
  localparam logic [OP_W-1:0]   OP_RSVD_B    = 3'd6;
  localparam logic [OP_W-1:0]   OP_RSVD_C    = 3'd7;
  localparam logic [MS_W-1:0]   GRACE_MAX_MS = MS_W'(86400000);
  localparam logic [KEY_W-1:0]  KEY_ALL      = '1;
  localparam logic [TID_W-1:0]  TID_ALL      = '1;
  localparam logic [TIME_W-1:0] T_MAX        = '1;
  localparam int unsigned       HOLD_CYCLES  = 200;
  localparam int unsigned       QUIET_LIMIT  = 3000;
  localparam int unsigned       DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [KEY_W-1:0]  key;
    logic [TID_W-1:0]  tid;
    logic              det;
    logic [TIME_W-1:0] evt;
    logic [TIME_W-1:0] crt;
  } thread_op_t;

  typedef struct packed {
    logic [STS_W-1:0]  status;
    logic [KEY_W-1:0]  key;
    logic [TID_W-1:0]  tid;
    logic [TIME_W-1:0] created;
    logic [TIME_W-1:0] started;
    logic [TIME_W-1:0] exited;
    logic              last;
  } leak_reply_t;

  typedef struct packed {
    thread_op_t       op;
    logic             typed;
    logic [STS_W-1:0] sts;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  tlt_in_if  op_ch ();
  tlt_out_if reply_ch ();
  tlt_cfg_if cfg_ch ();

  thread_leak_tracker_top dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (op_ch),
    .out_o (reply_ch),
    .cfg_i (cfg_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  entry_t          shadow_slot [DEPTH];
  logic            shadow_used [DEPTH];
  logic [MS_W-1:0] grace_ms = '0;
  leak_reply_t     fresh_replies [$];
  leak_reply_t     pending_replies [$];
  directed_row_t   directed_plan [$];
  int unsigned     sink_idle_max = 16;
  logic            sink_hold = 1'b0;
  int unsigned     mismatch_count = 0;

  function automatic void flag_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch: %s", what);
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want)
      flag_mismatch($sformatf("%s expected %h, got %h", name, want, got));
  endfunction

  function automatic logic [63:0] grace_in_ns();
    return 64'(grace_ms) * 64'(NS_PER_MS);
  endfunction

  function automatic int find_entry(input logic [KEY_W-1:0] key, input logic leaked);
    int hit;
    hit = -1;
    for (int s = DEPTH - 1; s >= 0; s--)
      if (shadow_used[s] && shadow_slot[s].leaked == leaked && shadow_slot[s].handle == key)
        hit = s;
    return hit;
  endfunction

  // Update the shadow table and queue the results of one operation.
  function automatic void apply_tracker_op(input thread_op_t op);
    leak_reply_t r;
    int live, dead, spot;
    r = '0;
    r.last = 1'b1;
    r.status = STS_IGNORED;
    live = find_entry(op.key, 1'b0);
    dead = find_entry(op.key, 1'b1);
    case (op.opcode)
      OP_ADD: begin
        spot = -1;
        for (int s = DEPTH - 1; s >= 0; s--)
          if (!shadow_used[s]) spot = s;
        if (live >= 0) begin
          r.status = STS_IGNORED;
        end else if (spot < 0) begin
          r.status = STS_FULL;
        end else begin
          shadow_used[spot] = 1'b1;
          shadow_slot[spot].leaked = 1'b0;
          shadow_slot[spot].released = op.det;
          shadow_slot[spot].handle = op.key;
          shadow_slot[spot].tid = op.tid;
          shadow_slot[spot].created = op.crt;
          shadow_slot[spot].started = op.evt;
          shadow_slot[spot].exited = '0;
          r.status = STS_OK;
        end
      end
      OP_JOIN, OP_DETACH: begin
        if (live >= 0) begin
          shadow_slot[live].released = 1'b1;
          r.status = STS_OK;
        end else if (dead >= 0) begin
          shadow_used[dead] = 1'b0;
          r.status = STS_OK;
        end
      end
      OP_EXIT: begin
        if (live >= 0) begin
          r.status = STS_OK;
          if (shadow_slot[live].released) begin
            shadow_used[live] = 1'b0;
          end else begin
            // the newer leak replaces an older one with the same key
            if (dead >= 0) shadow_used[dead] = 1'b0;
            shadow_slot[live].leaked = 1'b1;
            shadow_slot[live].exited = op.evt;
          end
        end
      end
      OP_REPORT: begin
        r.status = STS_NO_DUE;
        for (int s = 0; s < DEPTH; s++)
          if (shadow_used[s] && shadow_slot[s].leaked &&
              {1'b0, shadow_slot[s].exited} + grace_in_ns() < {1'b0, op.evt}) begin
            fresh_replies.push_back('{STS_LEAK, shadow_slot[s].handle, shadow_slot[s].tid,
                                      shadow_slot[s].created, shadow_slot[s].started,
                                      shadow_slot[s].exited, 1'b0});
            shadow_used[s] = 1'b0;
          end
        // mark the final record
        if (fresh_replies.size() > 0) begin
          r = fresh_replies.pop_back();
          r.last = 1'b1;
        end
      end
      default: ;
    endcase
    fresh_replies.push_back(r);
  endfunction

  function automatic thread_op_t mk_op(input logic [OP_W-1:0] opc, input logic [KEY_W-1:0] key,
                                       input logic [TID_W-1:0] tid, input logic det,
                                       input logic [TIME_W-1:0] evt,
                                       input logic [TIME_W-1:0] crt);
    thread_op_t op;
    op.opcode = opc;
    op.key = key;
    op.tid = tid;
    op.det = det;
    op.evt = evt;
    op.crt = crt;
    return op;
  endfunction

  function automatic void plan_row(input thread_op_t op, input logic typed,
                                   input logic [STS_W-1:0] sts);
    directed_plan.push_back('{op, typed, sts});
  endfunction

  task automatic send_op(input thread_op_t op, input int unsigned gap, input logic typed,
                         input logic [STS_W-1:0] sts);
    leak_reply_t r;
    if (gap > 0) begin
      op_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    op_ch.valid <= 1'b1;
    op_ch.opcode <= op.opcode;
    op_ch.thread_key <= op.key;
    op_ch.kernel_tid <= op.tid;
    op_ch.detached_at_create <= op.det;
    op_ch.event_time <= op.evt;
    op_ch.spawn_time <= op.crt;
    @(posedge clk);
    while (!op_ch.ready) @(posedge clk);
    fresh_replies.delete();
    apply_tracker_op(op);
    if (typed) begin
      r = '0;
      r.status = sts;
      r.last = 1'b1;
      pending_replies.push_back(r);
    end else begin
      foreach (fresh_replies[n]) pending_replies.push_back(fresh_replies[n]);
    end
  endtask

  task automatic wait_drained();
    op_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_replies.size() != 0);
  endtask

  task automatic set_grace(input logic [MS_W-1:0] ms);
    wait_drained();
    repeat (8) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.leak_delay_ms <= ms;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    grace_ms = ms;
  endtask

  // Mostly well-formed thread lifetimes over a small key pool, so the table
  // fills, leaks pile up and reports hit the due boundary.
  task automatic run_random(input int unsigned items, input int unsigned src_max);
    logic [KEY_W-1:0]  key_pool [40];
    logic [TIME_W-1:0] clock_ns;
    logic [63:0]       step_ns;
    thread_op_t        op;
    int unsigned       roll;
    int                leak_idx [$];
    int                pick;
    foreach (key_pool[p]) key_pool[p] = {$urandom, $urandom};
    clock_ns = TIME_W'({$urandom, $urandom} >> 2);
    step_ns = grace_in_ns() / 20 + 64'd50;
    repeat (items) begin
      clock_ns = clock_ns + TIME_W'((64'($urandom_range(0, 1000)) * step_ns) / 64'd1000);
      op = mk_op(OP_ADD, key_pool[$urandom_range(0, 39)], TID_W'($urandom),
                 ($urandom_range(0, 3) == 0), clock_ns, TIME_W'({$urandom, $urandom}));
      roll = $urandom_range(0, 99);
      if (roll < 34) begin
        op.opcode = OP_ADD;
      end else if (roll < 44) begin
        op.opcode = OP_JOIN;
      end else if (roll < 52) begin
        op.opcode = OP_DETACH;
      end else if (roll < 78) begin
        op.opcode = OP_EXIT;
      end else if (roll < 92) begin
        op.opcode = OP_REPORT;
        op.key = {$urandom, $urandom};
        leak_idx.delete();
        for (int s = 0; s < DEPTH; s++)
          if (shadow_used[s] && shadow_slot[s].leaked) leak_idx.push_back(s);
        case ($urandom_range(0, 5))
          0, 1: op.evt = clock_ns;
          2, 3: begin
            // land on or just past the due time of one leak
            if (leak_idx.size() > 0) begin
              pick = leak_idx[$urandom_range(0, leak_idx.size() - 1)];
              op.evt = TIME_W'({1'b0, shadow_slot[pick].exited} + grace_in_ns() +
                               64'($urandom_range(0, 1)));
            end
          end
          4: op.evt = T_MAX;
          default: op.evt = '0;
        endcase
      end else if (roll < 96) begin
        case ($urandom_range(0, 2))
          0: op.opcode = OP_RSVD_A;
          1: op.opcode = OP_RSVD_B;
          default: op.opcode = OP_RSVD_C;
        endcase
      end else begin
        op.opcode = $urandom_range(0, 1) ? OP_EXIT : OP_DETACH;
        op.key = {$urandom, $urandom};
      end
      if ($urandom_range(0, 49) == 0) wait_drained();
      send_op(op, $urandom_range(0, src_max), 1'b0, STS_OK);
    end
  endtask

  initial begin : result_sink
    int unsigned stall;
    leak_reply_t got, want;
    reply_ch.ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      stall = $urandom_range(0, sink_idle_max);
      if (sink_hold) begin
        stall = HOLD_CYCLES;
        sink_hold = 1'b0;
      end
      if (stall > 0) begin
        reply_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      reply_ch.ready <= 1'b1;
      @(posedge clk);
      while (!reply_ch.valid) @(posedge clk);
      got = '{reply_ch.status, reply_ch.leak_key, reply_ch.leak_tid,
              reply_ch.leak_spawn_time, reply_ch.leak_start_time,
              reply_ch.leak_exit_time, reply_ch.last};
      if (pending_replies.size() == 0) begin
        flag_mismatch($sformatf("unexpected result beat, status %0d", got.status));
      end else begin
        want = pending_replies.pop_front();
        check_field("status", 64'(want.status), 64'(got.status));
        check_field("leak_key", want.key, got.key);
        check_field("leak_tid", 64'(want.tid), 64'(got.tid));
        check_field("leak_spawn_time", 64'(want.created), 64'(got.created));
        check_field("leak_start_time", 64'(want.started), 64'(got.started));
        check_field("leak_exit_time", 64'(want.exited), 64'(got.exited));
        check_field("last", 64'(want.last), 64'(got.last));
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (op_ch.valid && op_ch.ready) || (reply_ch.valid && reply_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    logic [KEY_W-1:0] fill_base;
    op_ch.valid <= 1'b0;
    op_ch.opcode <= OP_ADD;
    op_ch.thread_key <= '0;
    op_ch.kernel_tid <= '0;
    op_ch.detached_at_create <= 1'b0;
    op_ch.event_time <= '0;
    op_ch.spawn_time <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.leak_delay_ms <= '0;
    foreach (shadow_used[s]) shadow_used[s] = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, grace period zero after reset
    plan_row(mk_op(OP_REPORT, '0, '0, 1'b0, '0, '0), 1'b1, STS_NO_DUE);
    plan_row(mk_op(OP_JOIN, 64'h5, '0, 1'b0, '0, '0), 1'b1, STS_IGNORED);
    plan_row(mk_op(OP_EXIT, 64'h5, '0, 1'b0, '0, '0), 1'b1, STS_IGNORED);
    plan_row(mk_op(OP_ADD, '0, '0, 1'b0, '0, '0), 1'b1, STS_OK);
    plan_row(mk_op(OP_ADD, '0, '0, 1'b0, '0, '0), 1'b1, STS_IGNORED);
    plan_row(mk_op(OP_ADD, KEY_ALL, TID_ALL, 1'b1, T_MAX, T_MAX), 1'b1, STS_OK);
    plan_row(mk_op(OP_EXIT, KEY_ALL, '0, 1'b0, 63'd7, '0), 1'b1, STS_OK);
    plan_row(mk_op(OP_EXIT, '0, '0, 1'b0, '0, '0), 1'b1, STS_OK);
    plan_row(mk_op(OP_ADD, '0, 22'd3, 1'b0, 63'd10, 63'd9), 1'b1, STS_OK);
    plan_row(mk_op(OP_EXIT, '0, '0, 1'b0, 63'd5, '0), 1'b1, STS_OK);
    plan_row(mk_op(OP_REPORT, '0, '0, 1'b0, 63'd5, '0), 1'b1, STS_NO_DUE);
    plan_row(mk_op(OP_REPORT, '0, '0, 1'b0, 63'd6, '0), 1'b0, STS_OK);
    plan_row(mk_op(OP_ADD, 64'hA5A5_5A5A_0F0F_F0F0, 22'h2AAAAA, 1'b0, 63'd20, 63'd19),
             1'b1, STS_OK);
    plan_row(mk_op(OP_DETACH, 64'hA5A5_5A5A_0F0F_F0F0, '0, 1'b0, '0, '0), 1'b1, STS_OK);
    plan_row(mk_op(OP_EXIT, 64'hA5A5_5A5A_0F0F_F0F0, '0, 1'b0, 63'd30, '0), 1'b1, STS_OK);
    plan_row(mk_op(OP_ADD, 64'h1234_5678_9ABC_DEF0, 22'h155555, 1'b0, 63'd31, 63'd30),
             1'b1, STS_OK);
    plan_row(mk_op(OP_EXIT, 64'h1234_5678_9ABC_DEF0, '0, 1'b0, 63'd40, '0), 1'b1, STS_OK);
    plan_row(mk_op(OP_JOIN, 64'h1234_5678_9ABC_DEF0, '0, 1'b0, '0, '0), 1'b1, STS_OK);
    plan_row(mk_op(OP_ADD, 64'h8000_0000_0000_0001, 22'd1, 1'b0, 63'd41, 63'd40),
             1'b1, STS_OK);
    plan_row(mk_op(OP_JOIN, 64'h8000_0000_0000_0001, '0, 1'b0, '0, '0), 1'b1, STS_OK);
    plan_row(mk_op(OP_EXIT, 64'h8000_0000_0000_0001, '0, 1'b0, 63'd45, '0), 1'b1, STS_OK);
    plan_row(mk_op(OP_RSVD_A, '0, '0, 1'b0, '0, '0), 1'b1, STS_IGNORED);
    plan_row(mk_op(OP_RSVD_B, '0, '0, 1'b0, '0, '0), 1'b1, STS_IGNORED);
    plan_row(mk_op(OP_RSVD_C, '0, '0, 1'b0, '0, '0), 1'b1, STS_IGNORED);
    plan_row(mk_op(OP_REPORT, '0, '0, 1'b0, T_MAX, '0), 1'b1, STS_NO_DUE);
    foreach (directed_plan[i])
      send_op(directed_plan[i].op, $urandom_range(0, 16), directed_plan[i].typed,
              directed_plan[i].sts);

    // fill every slot, overflow once, leak them all, report all in one go
    set_grace(GRACE_MAX_MS);
    sink_idle_max = 4;
    fill_base = {$urandom, $urandom};
    for (int k = 0; k < DEPTH; k++)
      send_op(mk_op(OP_ADD, fill_base + KEY_W'(k), TID_W'($urandom), 1'b0, TIME_W'(k),
                    TIME_W'({$urandom, $urandom})), 0, 1'b0, STS_OK);
    send_op(mk_op(OP_ADD, ~fill_base, '0, 1'b0, '0, '0), 0, 1'b1, STS_FULL);
    for (int k = 0; k < DEPTH; k++)
      send_op(mk_op(OP_EXIT, fill_base + KEY_W'(k), '0, 1'b0, TIME_W'(k * 1000 + 1), '0),
              0, 1'b0, STS_OK);
    // stall the output while operations keep coming
    sink_hold = 1'b1;
    send_op(mk_op(OP_REPORT, '0, '0, 1'b0, T_MAX, '0), 0, 1'b0, STS_OK);
    send_op(mk_op(OP_ADD, fill_base, '0, 1'b0, 63'd5, 63'd4), 0, 1'b1, STS_OK);
    send_op(mk_op(OP_EXIT, fill_base, '0, 1'b0, T_MAX, '0), 0, 1'b1, STS_OK);
    // exit time plus grace exceeds the time width: never due
    send_op(mk_op(OP_REPORT, '0, '0, 1'b0, T_MAX, '0), 0, 1'b1, STS_NO_DUE);
    repeat (4)
      send_op(mk_op(OP_ADD, {$urandom, $urandom}, TID_W'($urandom), 1'b0,
                    TIME_W'({$urandom, $urandom}), TIME_W'({$urandom, $urandom})),
              0, 1'b0, STS_OK);
    wait_drained();

    set_grace('0);
    sink_idle_max = 16;
    run_random(80, 16);
    set_grace(GRACE_MAX_MS);
    sink_idle_max = 0;
    run_random(80, 0);
    set_grace(27'h3FF_FFFF);
    sink_idle_max = 0;
    run_random(80, 16);
    set_grace(MS_W'($urandom_range(1, 999)));
    sink_idle_max = 16;
    run_random(80, 0);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_replies.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
